/* sv/mqm_pkg.sv */
// mqm_pkg: shared constants and types for the mDNS query matcher.
// Depends on nothing; imported by the matcher and its checker.
package mqm_pkg;

   // Sizes of the hostname store and the packet
   localparam int unsigned MAX_HOST_LEN   = 32;
   localparam int unsigned MAX_PACKET_LEN = 255;
   localparam int unsigned HDR_LEN        = 12;

   // Result status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_REPLY    = 2'd0;
   localparam status_type ST_NO_MATCH = 2'd1;
   localparam status_type ST_BAD_LEN  = 2'd2;
   localparam status_type ST_BAD_HDR  = 2'd3;

   // Configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_HOST_LEN     = 3'd0;
   localparam csr_index_type CSR_HOST_BYTES_0 = 3'd1;
   localparam csr_index_type CSR_HOST_BYTES_1 = 3'd2;
   localparam csr_index_type CSR_HOST_BYTES_2 = 3'd3;
   localparam csr_index_type CSR_HOST_BYTES_3 = 3'd4;

   // Characters of the label "local", by position
   function automatic logic [7:0] suffix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h6C;
         3'd1:    ch = 8'h6F;
         3'd2:    ch = 8'h63;
         3'd3:    ch = 8'h61;
         3'd4:    ch = 8'h6C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

/* sv/mdns_query_matcher.sv */
// mdns_query_matcher: walks an mDNS query byte by byte and reports whether
// it asks for this host's A record. Depends on mqm_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_byte[7:0], req_last_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_status[1:0]
//   csr      in         csr_write            csr_index[2:0], csr_data[63:0]
//
// One byte is taken every cycle while req_stall is low; the parse state
// updates in the cycle it is taken, and the status of a packet shows in the
// cycle after its last byte. req_stall rises only while a status beat waits
// on a stalled rsp side. Synchronous reset clears the parse state, the
// hostname registers and the result valid flag.
module mdns_query_matcher
   import mqm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   input  logic          csr_write,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);

   // Parse phases
   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_NAME_LEN = 3'd1;
   localparam logic [2:0] PH_LABEL    = 3'd2;
   localparam logic [2:0] PH_PTR2     = 3'd3;
   localparam logic [2:0] PH_TC       = 3'd4;
   localparam logic [2:0] PH_DONE     = 3'd5;

   localparam logic [6:0] CMP_LIMIT = 7'h7F;
   localparam logic [8:0] POS_LIMIT = 9'(MAX_PACKET_LEN);

   // Configuration
   logic [5:0]         host_len_ff;
   logic [3:0][63:0]   host_bytes_ff;
   logic [31:0][7:0]   host_byte_view;

   // Parse state
   logic [8:0]   byte_position_ff, byte_position_in;
   logic [2:0]   parse_phase_ff, parse_phase_in;
   logic [15:0]  question_total_ff, question_total_in;
   logic [15:0]  questions_done_ff, questions_done_in;
   logic [7:0]   label_skip_left_ff, label_skip_left_in;
   logic [6:0]   name_compare_pos_ff, name_compare_pos_in;
   logic         name_still_equal_ff, name_still_equal_in;
   logic [31:0]  type_class_bytes_ff, type_class_bytes_in;
   logic         answer_found_ff, answer_found_in;
   logic         header_bad_ff, header_bad_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;

   logic         req_beat;
   logic         host_usable;
   logic [7:0]   hl8;
   logic [6:0]   host_idx;
   logic [7:0]   exp_byte;
   logic         exp_valid;
   logic         exp_match;
   logic [7:0]   suffix_off;
   logic [8:0]   count;
   logic [15:0]  qtype;
   logic [15:0]  qclass;
   logic [15:0]  done_next;

   assign host_byte_view = host_bytes_ff;
   assign req_stall      = rsp_valid_ff & rsp_stall;
   assign req_beat       = req_valid & ~req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;

   assign hl8         = {2'b00, host_len_ff};
   assign host_usable = (host_len_ff != 6'd0) && (hl8 <= 8'(MAX_HOST_LEN)) &&
                        (hl8 <= 8'd32);

   // Expected byte of <len><hostname><5>local<0> at the compare position
   always_comb begin
      host_idx   = name_compare_pos_ff - 7'd1;
      suffix_off = {1'b0, name_compare_pos_ff} - hl8 - 8'd2;
      exp_byte   = 8'h00;
      exp_valid  = 1'b0;
      if (name_compare_pos_ff == 7'd0) begin
         exp_byte  = {2'b00, host_len_ff};
         exp_valid = 1'b1;
      end else if ({1'b0, name_compare_pos_ff} <= hl8) begin
         exp_byte  = host_byte_view[host_idx[4:0]];
         exp_valid = (host_idx < 7'd32);
      end else if ({1'b0, name_compare_pos_ff} == hl8 + 8'd1) begin
         exp_byte  = 8'd5;
         exp_valid = 1'b1;
      end else if ({1'b0, name_compare_pos_ff} <= hl8 + 8'd6) begin
         exp_byte  = suffix_char(suffix_off[2:0]);
         exp_valid = 1'b1;
      end else if ({1'b0, name_compare_pos_ff} == hl8 + 8'd7) begin
         exp_byte  = 8'h00;
         exp_valid = 1'b1;
      end
   end

   // Type and class as they stand once the current byte is shifted in
   assign exp_match = exp_valid && (exp_byte == req_data_byte);
   assign qtype     = type_class_bytes_ff[23:8];
   assign qclass    = {type_class_bytes_ff[7:0], req_data_byte};
   assign done_next = questions_done_ff + 16'd1;

   // Advance the parse state by one byte
   always_comb begin
      byte_position_in    = byte_position_ff;
      parse_phase_in      = parse_phase_ff;
      question_total_in   = question_total_ff;
      questions_done_in   = questions_done_ff;
      label_skip_left_in  = label_skip_left_ff;
      name_compare_pos_in = name_compare_pos_ff;
      name_still_equal_in = name_still_equal_ff;
      type_class_bytes_in = type_class_bytes_ff;
      answer_found_in     = answer_found_ff;
      header_bad_in       = header_bad_ff;

      if (byte_position_ff <= POS_LIMIT) begin
         byte_position_in = byte_position_ff + 9'd1;

         // Compare name bytes while a name is walked
         if ((parse_phase_ff == PH_NAME_LEN || parse_phase_ff == PH_LABEL ||
              parse_phase_ff == PH_PTR2) && name_compare_pos_ff < CMP_LIMIT) begin
            if (!exp_match) name_still_equal_in = 1'b0;
            name_compare_pos_in = name_compare_pos_ff + 7'd1;
         end

         case (parse_phase_ff)
            PH_HEADER: begin
               if (byte_position_ff == 9'd2 && (req_data_byte & 8'hF8) != 8'h00)
                  header_bad_in = 1'b1;
               if (byte_position_ff == 9'd4) question_total_in = {req_data_byte, 8'h00};
               if (byte_position_ff == 9'd5)
                  question_total_in = {question_total_ff[15:8], req_data_byte};
               if (byte_position_ff == 9'(HDR_LEN - 1)) begin
                  parse_phase_in = (question_total_ff != 16'd0) ? PH_NAME_LEN : PH_DONE;
                  name_compare_pos_in = 7'd0;
                  name_still_equal_in = 1'b1;
               end
            end
            PH_NAME_LEN: begin
               if (req_data_byte == 8'h00) begin
                  name_still_equal_in = name_still_equal_in && host_usable &&
                                        ({1'b0, name_compare_pos_in} == hl8 + 8'd8);
                  parse_phase_in      = PH_TC;
                  label_skip_left_in  = 8'd4;
                  type_class_bytes_in = 32'd0;
               end else if ((req_data_byte & 8'hC0) == 8'hC0) begin
                  parse_phase_in = PH_PTR2;
               end else begin
                  label_skip_left_in = req_data_byte;
                  parse_phase_in     = PH_LABEL;
               end
            end
            PH_LABEL: begin
               label_skip_left_in = label_skip_left_ff - 8'd1;
               if (label_skip_left_in == 8'd0) parse_phase_in = PH_NAME_LEN;
            end
            PH_PTR2: begin
               name_still_equal_in = name_still_equal_in && host_usable &&
                                     ({1'b0, name_compare_pos_in} == hl8 + 8'd8);
               parse_phase_in      = PH_TC;
               label_skip_left_in  = 8'd4;
               type_class_bytes_in = 32'd0;
            end
            PH_TC: begin
               type_class_bytes_in = {type_class_bytes_ff[23:0], req_data_byte};
               label_skip_left_in  = label_skip_left_ff - 8'd1;
               if (label_skip_left_in == 8'd0) begin
                  if ((qtype == 16'd1 || qtype == 16'd255) &&
                      (qclass & 16'h7FFF) == 16'd1 && name_still_equal_ff) begin
                     answer_found_in = 1'b1;
                     parse_phase_in  = PH_DONE;
                  end else begin
                     questions_done_in = done_next;
                     if (done_next == question_total_ff) begin
                        parse_phase_in = PH_DONE;
                     end else begin
                        parse_phase_in      = PH_NAME_LEN;
                        name_compare_pos_in = 7'd0;
                        name_still_equal_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Status of a packet on its last byte
   assign count = byte_position_in;
   always_comb begin
      if (count < 9'(HDR_LEN) || count > POS_LIMIT) rsp_status_in = ST_BAD_LEN;
      else if (header_bad_in)                       rsp_status_in = ST_BAD_HDR;
      else if (answer_found_in)                     rsp_status_in = ST_REPLY;
      else                                          rsp_status_in = ST_NO_MATCH;
   end

   // Load a status beat on a last byte, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat && req_last_byte) rsp_valid_in = 1'b1;
      else if (!rsp_stall)           rsp_valid_in = 1'b0;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         host_len_ff   <= '0;
         host_bytes_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HOST_LEN:     host_len_ff      <= csr_data[5:0];
            CSR_HOST_BYTES_0: host_bytes_ff[0] <= csr_data;
            CSR_HOST_BYTES_1: host_bytes_ff[1] <= csr_data;
            CSR_HOST_BYTES_2: host_bytes_ff[2] <= csr_data;
            CSR_HOST_BYTES_3: host_bytes_ff[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Parse state: advance on each byte beat, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || (req_beat && req_last_byte)) begin
         byte_position_ff    <= '0;
         parse_phase_ff      <= PH_HEADER;
         question_total_ff   <= '0;
         questions_done_ff   <= '0;
         label_skip_left_ff  <= '0;
         name_compare_pos_ff <= '0;
         name_still_equal_ff <= 1'b1;
         type_class_bytes_ff <= '0;
         answer_found_ff     <= 1'b0;
         header_bad_ff       <= 1'b0;
      end else if (req_beat) begin
         byte_position_ff    <= byte_position_in;
         parse_phase_ff      <= parse_phase_in;
         question_total_ff   <= question_total_in;
         questions_done_ff   <= questions_done_in;
         label_skip_left_ff  <= label_skip_left_in;
         name_compare_pos_ff <= name_compare_pos_in;
         name_still_equal_ff <= name_still_equal_in;
         type_class_bytes_ff <= type_class_bytes_in;
         answer_found_ff     <= answer_found_in;
         header_bad_ff       <= header_bad_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && req_last_byte) begin
         rsp_status_ff <= rsp_status_in;
      end
   end

endmodule

/* sv/mqm_checker.sv */
// mqm_props: port-level assertions for mdns_query_matcher, bound to it below.
// Depends on mqm_pkg for the status type.
module mqm_props
   import mqm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status
);

   status_type status_seen;
   assign status_seen = rsp_status;

   // No status beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("status beat after reset");

   // A stalled status beat holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(status_seen))
      else $error("stalled status beat changed");

   // A new status beat follows an accepted last byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && rsp_stall) |->
         $past(req_valid && !req_stall && req_last_byte))
      else $error("status beat without a last byte");

   // A byte that is not last leaves no status beat behind
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_last_byte |=> !rsp_valid)
      else $error("status beat after a middle byte");

endmodule

bind mdns_query_matcher mqm_props u_mqm_props (.*);

/* dv/mqm_checker.sv */
// mqm_checker: tracks the byte stream into the mDNS query matcher, predicts the
// status of each packet and compares it with every status beat that leaves.
// Depends on mqm_pkg; instantiated beside the matcher by tb_mdns_query_matcher.
module mqm_checker
   import mqm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic [1:0]    rsp_status,
   input  logic          csr_write,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data,
   output int            mismatch_count,
   output int            status_pending
);

   typedef enum logic [2:0] {
      WALK_HEADER,
      WALK_LABEL_LEN,
      WALK_LABEL,
      WALK_POINTER,
      WALK_TYPE_CLASS,
      WALK_DONE
   } walk_phase_type;

   localparam logic [39:0] LOCAL_LABEL    = "local";
   localparam int          NAME_CMP_LIMIT = 127;
   localparam logic [8:0]  NO_BYTE        = 9'h100;

   // Shadow copy of the hostname registers
   logic [5:0]    host_len;
   logic [63:0]   host_words [4];

   // Shadow copy of the packet walk
   logic [8:0]      byte_pos;
   walk_phase_type  phase;
   logic [15:0]     qd_total;
   logic [15:0]     qd_done;
   logic [7:0]      skip_left;
   logic [6:0]      cmp_pos;
   logic            name_equal;
   logic [31:0]     tc_bytes;
   logic            found;
   logic            hdr_bad;

   status_type    status_queue [$];
   int            errors = 0;

   task automatic clear_walk();
      byte_pos   = '0;
      phase      = WALK_HEADER;
      qd_total   = '0;
      qd_done    = '0;
      skip_left  = '0;
      cmp_pos    = '0;
      name_equal = 1'b1;
      tc_bytes   = '0;
      found      = 1'b0;
      hdr_bad    = 1'b0;
   endtask

   // Byte that the wanted name <len><host>5"local"0 holds at offset k
   function automatic logic [8:0] wanted_byte(input int k);
      int hl;
      int i;
      int j;
      hl = host_len;
      if (k == 0) return {3'b000, host_len};
      if (k <= hl) begin
         i = k - 1;
         if (i >= 32) return NO_BYTE;
         return {1'b0, host_words[i / 8][(i % 8) * 8 +: 8]};
      end
      if (k == hl + 1) return 9'd5;
      if (k <= hl + 6) begin
         j = k - hl - 2;
         return {1'b0, LOCAL_LABEL[(39 - 8 * j) -: 8]};
      end
      if (k == hl + 7) return 9'd0;
      return NO_BYTE;
   endfunction

   task automatic compare_name_byte(input logic [7:0] b);
      if (int'(cmp_pos) < NAME_CMP_LIMIT) begin
         if (wanted_byte(int'(cmp_pos)) != {1'b0, b}) name_equal = 1'b0;
         cmp_pos = cmp_pos + 7'd1;
      end
   endtask

   task automatic close_name();
      logic usable;
      usable = host_len != 0 && int'(host_len) <= MAX_HOST_LEN && host_len <= 32;
      name_equal = name_equal && usable && (int'(cmp_pos) == int'(host_len) + 8);
      phase      = WALK_TYPE_CLASS;
      skip_left  = 8'd4;
      tc_bytes   = '0;
   endtask

   // Advance the walk by one byte of the packet
   task automatic walk_byte(input logic [8:0] p, input logic [7:0] b);
      logic [15:0] qtype;
      logic [15:0] qclass;
      case (phase)
         WALK_HEADER: begin
            if (p == 9'd2 && (b & 8'hF8) != 8'h00) hdr_bad = 1'b1;
            if (p == 9'd4) qd_total = {b, 8'h00};
            if (p == 9'd5) qd_total[7:0] = b;
            if (p == 9'd11) begin
               phase      = (qd_total != 0) ? WALK_LABEL_LEN : WALK_DONE;
               cmp_pos    = '0;
               name_equal = 1'b1;
            end
         end
         WALK_LABEL_LEN: begin
            compare_name_byte(b);
            if (b == 8'h00) begin
               close_name();
            end else if ((b & 8'hC0) == 8'hC0) begin
               phase = WALK_POINTER;
            end else begin
               skip_left = b;
               phase     = WALK_LABEL;
            end
         end
         WALK_LABEL: begin
            compare_name_byte(b);
            skip_left = skip_left - 8'd1;
            if (skip_left == 0) phase = WALK_LABEL_LEN;
         end
         WALK_POINTER: begin
            compare_name_byte(b);
            close_name();
         end
         WALK_TYPE_CLASS: begin
            tc_bytes  = {tc_bytes[23:0], b};
            skip_left = skip_left - 8'd1;
            if (skip_left == 0) begin
               qtype  = tc_bytes[31:16];
               qclass = tc_bytes[15:0];
               if ((qtype == 16'd1 || qtype == 16'd255) &&
                   (qclass & 16'h7FFF) == 16'd1 && name_equal) begin
                  found = 1'b1;
                  phase = WALK_DONE;
               end else begin
                  qd_done = qd_done + 16'd1;
                  if (qd_done == qd_total) begin
                     phase = WALK_DONE;
                  end else begin
                     phase      = WALK_LABEL_LEN;
                     cmp_pos    = '0;
                     name_equal = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Take one accepted byte; on the last one queue the packet status
   task automatic take_byte(input logic [7:0] b, input logic last);
      status_type st;
      if (int'(byte_pos) <= MAX_PACKET_LEN) begin
         walk_byte(byte_pos, b);
         byte_pos = byte_pos + 9'd1;
      end
      if (last) begin
         if (int'(byte_pos) < HDR_LEN || int'(byte_pos) > MAX_PACKET_LEN) st = ST_BAD_LEN;
         else if (hdr_bad) st = ST_BAD_HDR;
         else if (found) st = ST_REPLY;
         else st = ST_NO_MATCH;
         status_queue.push_back(st);
         clear_walk();
      end
   endtask

   always @(posedge clock) begin : watch
      status_type want;
      if (reset) begin
         host_len = '0;
         for (int k = 0; k < 4; k++) host_words[k] = '0;
         status_queue.delete();
         clear_walk();
      end else begin
         // Check the outgoing beat before this edge's byte can queue a new status
         if (rsp_valid && !rsp_stall) begin
            if (status_queue.size() == 0) begin
               $display("%0t unexpected status beat: expected none, got %0d",
                        $time, rsp_status);
               errors++;
            end else begin
               want = status_queue.pop_front();
               if (rsp_status !== want) begin
                  $display("%0t status mismatch: expected %0d, got %0d",
                           $time, want, rsp_status);
                  errors++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_HOST_LEN:     host_len      = csr_data[5:0];
               CSR_HOST_BYTES_0: host_words[0] = csr_data;
               CSR_HOST_BYTES_1: host_words[1] = csr_data;
               CSR_HOST_BYTES_2: host_words[2] = csr_data;
               CSR_HOST_BYTES_3: host_words[3] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) take_byte(req_data_byte, req_last_byte);
      end
      mismatch_count <= errors;
      status_pending <= status_queue.size();
   end

endmodule

/* dv/tb_mdns_query_matcher.sv */
// tb_mdns_query_matcher: drives mDNS packets and hostname settings into the
// matcher with random gaps and stalls; mqm_checker predicts and compares.
// Depends on mqm_pkg, mqm_checker and mdns_query_matcher.
module tb_mdns_query_matcher;
   import mqm_pkg::*;

   typedef enum int {
      NM_OWN,
      NM_FLIPPED,
      NM_OWN_PTR,
      NM_LABELS,
      NM_POINTER,
      NM_LONG_LABEL
   } name_kind_type;

   localparam logic [15:0] QTYPE_A    = 16'd1;
   localparam logic [15:0] QTYPE_AAAA = 16'd28;
   localparam logic [15:0] QTYPE_ANY  = 16'd255;
   localparam logic [15:0] QCLASS_IN  = 16'd1;
   localparam logic [15:0] QCLASS_CH  = 16'd3;
   localparam logic [15:0] QCLASS_QU  = 16'h8001;
   localparam logic [39:0] LOCAL_WORD = "local";
   localparam int          BYTE_GOAL  = 300;
   localparam int          DRAIN_MAX  = 2000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   logic [7:0]      req_data_byte;
   logic            req_last_byte;
   logic            rsp_valid;
   logic            rsp_stall;
   logic [1:0]      rsp_status;
   logic            csr_write;
   csr_index_type   csr_index;
   logic [63:0]     csr_data;
   int              mismatches;
   int              pending;

   logic            quiet;
   int              bytes_sent;
   logic [7:0]      pkt [$];
   logic [5:0]      host_len_cfg;
   logic [63:0]     host_word [4];

   mdns_query_matcher u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   mqm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatches),
      .status_pending (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop in case the flow hangs
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Status side: stall each beat at random once it shows
   initial begin : status_sink
      int hold;
      rsp_stall = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) hold = quiet ? 0 : $urandom_range(0, 3);
         else if (rsp_valid && hold > 0) hold--;
         rsp_stall <= (hold > 0);
      end
   end

   // Send the packet in pkt, one beat per byte, with a random gap before each
   task automatic send_packet();
      int gap;
      for (int n = 0; n < pkt.size(); n++) begin
         gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= pkt[n];
         req_last_byte <= (n == pkt.size() - 1);
         @(posedge clock);
         while (req_stall) @(posedge clock);
         bytes_sent++;
      end
   endtask

   // Drop valid and hold until every queued status has left or DRAIN_MAX runs out
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (pending != 0 && waited < DRAIN_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Write all five hostname registers; fill 0 random, 1 all ones, 2 all zeros
   task automatic write_host(input logic [5:0] len, input int fill);
      logic [63:0] word;
      for (int k = 0; k < 4; k++) begin
         if (fill == 1) host_word[k] = '1;
         else if (fill == 2) host_word[k] = '0;
         else host_word[k] = {$urandom, $urandom};
      end
      host_len_cfg = len;
      word = {$urandom, $urandom};
      word[5:0] = len;
      csr_write <= 1'b1;
      csr_index <= CSR_HOST_LEN;
      csr_data  <= word;
      @(posedge clock);
      csr_index <= CSR_HOST_BYTES_0;
      csr_data  <= host_word[0];
      @(posedge clock);
      csr_index <= CSR_HOST_BYTES_1;
      csr_data  <= host_word[1];
      @(posedge clock);
      csr_index <= CSR_HOST_BYTES_2;
      csr_data  <= host_word[2];
      @(posedge clock);
      csr_index <= CSR_HOST_BYTES_3;
      csr_data  <= host_word[3];
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic put_header(input logic [7:0] flags, input logic [15:0] qd);
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(flags);
      pkt.push_back(8'($urandom));
      pkt.push_back(qd[15:8]);
      pkt.push_back(qd[7:0]);
      repeat (6) pkt.push_back(8'($urandom));
   endtask

   // Hostname label, then optionally the label local and the root
   task automatic put_own_name(input logic with_suffix);
      pkt.push_back({2'b00, host_len_cfg});
      for (int i = 0; i < host_len_cfg; i++) begin
         if (i < 32) pkt.push_back(host_word[i / 8][(i % 8) * 8 +: 8]);
         else pkt.push_back(8'($urandom));
      end
      if (with_suffix) begin
         pkt.push_back(8'd5);
         for (int j = 0; j < 5; j++) pkt.push_back(LOCAL_WORD[(39 - 8 * j) -: 8]);
         pkt.push_back(8'd0);
      end
   endtask

   task automatic put_question(input name_kind_type kind, input logic [15:0] qtype,
                               input logic [15:0] qclass);
      int start;
      int n;
      start = pkt.size();
      case (kind)
         NM_OWN, NM_FLIPPED: put_own_name(1'b1);
         NM_OWN_PTR: begin
            put_own_name(1'b0);
            pkt.push_back(8'hC0 | 8'($urandom_range(0, 63)));
            pkt.push_back(8'($urandom));
         end
         NM_LABELS: begin
            repeat ($urandom_range(0, 3)) begin
               n = $urandom_range(1, 12);
               pkt.push_back(8'(n));
               repeat (n) pkt.push_back(8'($urandom));
            end
            if ($urandom_range(0, 1) == 0) begin
               pkt.push_back(8'd0);
            end else begin
               pkt.push_back(8'hC0 | 8'($urandom_range(0, 63)));
               pkt.push_back(8'($urandom));
            end
         end
         NM_POINTER: begin
            pkt.push_back(8'hC0 | 8'($urandom_range(0, 63)));
            pkt.push_back(8'($urandom));
         end
         default: begin
            n = $urandom_range(64, 191);
            pkt.push_back(8'(n));
            repeat (n) pkt.push_back(8'($urandom));
            pkt.push_back(8'd0);
         end
      endcase
      // Corrupt one byte of an otherwise exact name
      if (kind == NM_FLIPPED) begin
         n = start + $urandom_range(0, pkt.size() - start - 1);
         pkt[n] = pkt[n] ^ 8'($urandom_range(1, 255));
      end
      pkt.push_back(qtype[15:8]);
      pkt.push_back(qtype[7:0]);
      pkt.push_back(qclass[15:8]);
      pkt.push_back(qclass[7:0]);
   endtask

   task automatic pad_to(input int n);
      while (pkt.size() < n) pkt.push_back(8'($urandom));
   endtask

   task automatic trim_to(input int n);
      while (pkt.size() > n) pkt.delete(pkt.size() - 1);
   endtask

   // One random packet: mostly well-formed queries, some broken or noise
   task automatic random_packet();
      int pick;
      int nq;
      int qd;
      int draw;
      name_kind_type kind;
      logic [15:0] qtype;
      logic [15:0] qclass;
      logic [7:0] flags;
      pkt.delete();
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
         pad_to($urandom_range(1, 40));
      end else begin
         nq = $urandom_range(1, 3);
         qd = nq;
         case ($urandom_range(0, 9))
            0: qd = $urandom_range(0, 65535);
            1: qd = nq + 1;
            2: qd = nq - 1;
            default: ;
         endcase
         if (pick < 17) flags = 8'($urandom_range(0, 7)) | (8'h08 << $urandom_range(0, 4));
         else flags = 8'($urandom_range(0, 7));
         put_header(flags, 16'(qd));
         repeat (nq) begin
            draw = $urandom_range(0, 99);
            if (draw < 40) kind = NM_OWN;
            else if (draw < 55) kind = NM_FLIPPED;
            else if (draw < 75) kind = NM_LABELS;
            else if (draw < 85) kind = NM_POINTER;
            else if (draw < 96) kind = NM_OWN_PTR;
            else kind = NM_LONG_LABEL;
            draw = $urandom_range(0, 99);
            qtype = (draw < 60) ? QTYPE_A : (draw < 75) ? QTYPE_ANY : 16'($urandom);
            draw = $urandom_range(0, 99);
            qclass = (draw < 50) ? QCLASS_IN : (draw < 75) ? QCLASS_QU : 16'($urandom);
            put_question(kind, qtype, qclass);
         end
         pad_to(pkt.size() + $urandom_range(0, 4));
         if (pick >= 17 && pick < 25) trim_to($urandom_range(1, pkt.size()));
         else if (pick >= 95) pad_to($urandom_range(240, 270));
      end
      send_packet();
   endtask

   initial begin : stimulus
      logic [5:0] phase_len [10];
      int phase_end;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      csr_write     = 1'b0;
      csr_index     = CSR_HOST_LEN;
      csr_data      = '0;
      quiet         = 1'b0;
      bytes_sent    = 0;
      host_len_cfg  = '0;
      for (int k = 0; k < 4; k++) host_word[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset: no hostname, so a well-formed query cannot match
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      settle();
      write_host(6'd5, 0);

      // Directed packets
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h07, 16'd1); put_question(NM_OWN, QTYPE_ANY, QCLASS_QU);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_CH);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_AAAA, QCLASS_IN);
      send_packet();
      // Query/response and opcode bits
      pkt.delete(); put_header(8'h80, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h08, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      // Question count: second question counted or ignored
      pkt.delete(); put_header(8'h00, 16'd2); put_question(NM_LABELS, QTYPE_A, QCLASS_IN);
      put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_LABELS, QTYPE_A, QCLASS_IN);
      put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd0); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'hFFFF); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      send_packet();
      // Compressed and corrupted names
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_POINTER, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN_PTR, QTYPE_A, QCLASS_IN);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_FLIPPED, QTYPE_A, QCLASS_IN);
      send_packet();
      // Truncated name, truncated type and class
      pkt.delete(); put_header(8'h00, 16'd1); put_own_name(1'b1); trim_to(pkt.size() - 2);
      send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      trim_to(pkt.size() - 2);
      send_packet();
      // Length limits, saturation and length before header
      pkt.delete(); pad_to(11); send_packet();
      pkt.delete(); pad_to(1); send_packet();
      pkt.delete(); put_header(8'h00, 16'd0); send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      pad_to(255); send_packet();
      pkt.delete(); put_header(8'h00, 16'd1); put_question(NM_OWN, QTYPE_A, QCLASS_IN);
      pad_to(256); send_packet();
      pkt.delete(); pad_to(300); send_packet();
      pkt.delete(); put_header(8'hF8, 16'd1); trim_to(5); send_packet();

      // Random phases over several hostname settings, extremes first
      phase_len[0] = 6'd0;
      phase_len[1] = 6'd1;
      phase_len[2] = 6'd32;
      phase_len[3] = 6'd33;
      phase_len[4] = 6'd63;
      for (int ph = 5; ph < 10; ph++) phase_len[ph] = 6'($urandom_range(1, 32));
      for (int ph = 0; ph < 10; ph++) begin
         settle();
         write_host(phase_len[ph], (ph == 2) ? 1 : (ph == 3) ? 2 : 0);
         phase_end = bytes_sent + BYTE_GOAL / 10;
         while (bytes_sent < phase_end) begin
            quiet = ($urandom_range(0, 7) == 0);
            random_packet();
            // Now and then hold off until the matcher has drained
            if ($urandom_range(0, 19) == 0) settle();
         end
      end

      quiet = 1'b0;
      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
